// ----- design/crt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_pkg
// Shared types and constants of the congruence sieve solver.
// ----------------------------------------------------------------------------
package crt_pkg;

  localparam int unsigned InFieldBits  = 16;
  localparam int unsigned OutFieldBits = 32;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOSOL = 2'd1,
    ST_RANGE = 2'd2,
    ST_OVF   = 2'd3
  } status_e;

endpackage

// ----- design/crt_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_div
// Restoring divider, one quotient bit per cycle, shared by all modulo steps.
// ----------------------------------------------------------------------------
module crt_div #(
  parameter int unsigned W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         busy_o,
  output logic         done_o,
  output logic [W-1:0] quotient_o,
  output logic [W-1:0] remainder_o
);
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W:0]    trial;

  assign trial = {rem_q, quo_q[W-1]};

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    den_d = den_q;
    cnt_d = cnt_q;
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i;
      den_d = divisor_i;
      cnt_d = CW'(W);
    end else if (cnt_q != '0) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = W'(trial - {1'b0, den_q});
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= !start_i && (cnt_q == CW'(1));
    end
  end

  assign busy_o      = (cnt_q != '0);
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

  // A new division is only started once the previous one has finished.
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_o) else $error("divider restarted while busy");
  // The remainder of a running division stays below the divisor.
  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o && !$past(start_i) |-> rem_q < den_q) else $error("remainder too big");
  a_done_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("done while busy");

endmodule

// ----- design/crt_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_mul
// Shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module crt_mul #(
  parameter int unsigned AW = 32,
  parameter int unsigned BW = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [AW-1:0]   a_i,
  input  logic [BW-1:0]   b_i,
  output logic            done_o,
  output logic [AW+BW-1:0] product_o
);
  localparam int unsigned CW = $clog2(BW + 1);

  logic [AW+BW-1:0] acc_q, acc_d, mc_q, mc_d;
  logic [BW-1:0]    mp_q, mp_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  always_comb begin
    acc_d = acc_q;
    mc_d  = mc_q;
    mp_d  = mp_q;
    cnt_d = cnt_q;
    if (start_i) begin
      acc_d = '0;
      mc_d  = (AW+BW)'(a_i);
      mp_d  = b_i;
      cnt_d = CW'(BW);
    end else if (cnt_q != '0) begin
      if (mp_q[0]) begin
        acc_d = acc_q + mc_q;
      end
      mc_d  = {mc_q[AW+BW-2:0], 1'b0};
      mp_d  = {1'b0, mp_q[BW-1:1]};
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_o <= !start_i && (cnt_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    mc_q  <= mc_d;
    mp_q  <= mp_d;
  end

  assign product_o = acc_q;

endmodule

// ----- design/crt_sieve_solver.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_sieve_solver
// Solves a system of congruences by sieving, one pair per input word.
// ----------------------------------------------------------------------------
// Usage: each slave word carries one congruence (divisor, residual); tlast
// marks the last pair of a system. Only that last pair yields a master word
// with the solution and combined modulus in tdata and the status in tuser.
// A pair goes straight from the decision step to the finish step when the
// system is new or faulted. Otherwise the shared divider runs the modulo
// steps: one per Euclid step of the gcd plus five more. The sieve steps
// follow, one per cycle (up to divisor/gcd of them), then the serial
// multiply; the sieve sets the worst case.
// tready is high only between pairs. A finished result waits in the output
// register; the next pair is accepted meanwhile, and a second result waits
// until the first has been taken. Reset clears the running system and any
// pending result.
// ----------------------------------------------------------------------------
module crt_sieve_solver #(
  parameter int unsigned DIVISOR_BITS = 16,
  parameter int unsigned RESULT_BITS  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // divisor[15:0], residual[31:16]
  input  logic        s_axis_tlast,  // last_pair
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // solution[31:0], modulus[63:32]
  output logic [1:0]  m_axis_tuser   // status[1:0]
);
  import crt_pkg::*;

  localparam int unsigned DW = (DIVISOR_BITS < InFieldBits) ? DIVISOR_BITS : InFieldBits;
  localparam int unsigned RW = RESULT_BITS;
  localparam int unsigned XW = (RW > DW) ? RW : DW;

  typedef enum logic [11:0] {
    S_IDLE    = 12'b000000000001,
    S_DECIDE  = 12'b000000000010,
    S_GCD     = 12'b000000000100,
    S_MODSOL  = 12'b000000001000,
    S_MODR    = 12'b000000010000,
    S_MODCAND = 12'b000000100000,
    S_MODSTEP = 12'b000001000000,
    S_SIEVE   = 12'b000010000000,
    S_QUOT    = 12'b000100000000,
    S_MUL     = 12'b001000000000,
    S_FIN     = 12'b010000000000,
    S_WAITMUL = 12'b100000000000
  } state_e;

  state_e        state_q, state_d;
  status_e       fault_q, fault_d;
  logic          first_q, first_d, last_q, last_d;
  logic [RW-1:0] sol_q, sol_d, mod_q, mod_d, cand_q, cand_d;
  logic [DW-1:0] d_q, d_d, r_q, r_d, y_q, y_d, g_q, g_d, t_q, t_d;
  logic [DW-1:0] cm_q, cm_d, sm_q, sm_d;
  logic          ovalid_q, ovalid_d;
  logic [63:0]   odata_q, odata_d;
  status_e       ostat_q, ostat_d;

  logic          div_start, div_busy, div_done;
  logic [XW-1:0] div_a, div_b, div_quo, div_rem;
  logic          mul_start, mul_done;
  logic [RW+DW-1:0] mul_prod;
  logic [RW+DW-1:0] d_wide;
  logic [RW:0]   cand_sum;
  logic [DW:0]   cm_sum;

  crt_div #(.W(XW)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .dividend_i(div_a), .divisor_i(div_b),
    .busy_o(div_busy), .done_o(div_done),
    .quotient_o(div_quo), .remainder_o(div_rem)
  );

  crt_mul #(.AW(RW), .BW(DW)) u_mul (
    .clk_i, .rst_ni,
    .start_i(mul_start), .a_i(div_quo[RW-1:0]), .b_i(d_q),
    .done_o(mul_done), .product_o(mul_prod)
  );

  assign d_wide   = (RW+DW)'(d_q);
  assign cand_sum = {1'b0, cand_q} + {1'b0, mod_q};
  assign cm_sum   = {1'b0, cm_q} + {1'b0, sm_q};

  always_comb begin
    state_d  = state_q;
    fault_d  = fault_q;
    first_d  = first_q;
    last_d   = last_q;
    sol_d    = sol_q;
    mod_d    = mod_q;
    cand_d   = cand_q;
    d_d      = d_q;
    r_d      = r_q;
    y_d      = y_q;
    g_d      = g_q;
    t_d      = t_q;
    cm_d     = cm_q;
    sm_d     = sm_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    odata_d  = odata_q;
    ostat_d  = ostat_q;
    div_start = 1'b0;
    div_a     = '0;
    div_b     = '0;
    mul_start = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          d_d     = s_axis_tdata[DW-1:0];
          r_d     = s_axis_tdata[InFieldBits+DW-1:InFieldBits];
          last_d  = s_axis_tlast;
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_d = S_FIN;
        if (fault_q != ST_OK) begin
          state_d = S_FIN;
        end else if (r_q >= d_q) begin
          fault_d = ST_RANGE;
        end else if (first_q) begin
          first_d = 1'b0;
          if (d_wide[RW+DW-1:RW] != '0) begin
            fault_d = ST_OVF;
          end else begin
            sol_d = RW'(r_q);
            mod_d = d_wide[RW-1:0];
          end
        end else begin
          div_start = 1'b1;
          div_a     = XW'(mod_q);
          div_b     = XW'(d_q);
          y_d       = d_q;
          state_d   = S_GCD;
        end
      end
      S_GCD: begin
        if (div_done) begin
          if (div_rem == '0) begin
            g_d       = y_q;
            div_start = 1'b1;
            div_a     = XW'(sol_q);
            div_b     = XW'(y_q);
            state_d   = S_MODSOL;
          end else begin
            y_d       = div_rem[DW-1:0];
            div_start = 1'b1;
            div_a     = XW'(y_q);
            div_b     = div_rem;
          end
        end
      end
      S_MODSOL: begin
        if (div_done) begin
          t_d       = div_rem[DW-1:0];
          div_start = 1'b1;
          div_a     = XW'(r_q);
          div_b     = XW'(g_q);
          state_d   = S_MODR;
        end
      end
      S_MODR: begin
        if (div_done) begin
          if (div_rem[DW-1:0] != t_q) begin
            fault_d = ST_NOSOL;
            state_d = S_FIN;
          end else begin
            div_start = 1'b1;
            div_a     = XW'(sol_q);
            div_b     = XW'(d_q);
            state_d   = S_MODCAND;
          end
        end
      end
      S_MODCAND: begin
        if (div_done) begin
          cm_d      = div_rem[DW-1:0];
          div_start = 1'b1;
          div_a     = XW'(mod_q);
          div_b     = XW'(d_q);
          state_d   = S_MODSTEP;
        end
      end
      S_MODSTEP: begin
        if (div_done) begin
          sm_d    = div_rem[DW-1:0];
          cand_d  = sol_q;
          state_d = S_SIEVE;
        end
      end
      S_SIEVE: begin
        // cm tracks cand modulo the divisor, so no division per sieve step.
        if (cm_q == r_q) begin
          sol_d     = cand_q;
          div_start = 1'b1;
          div_a     = XW'(mod_q);
          div_b     = XW'(g_q);
          state_d   = S_QUOT;
        end else if (cand_sum[RW]) begin
          fault_d = ST_OVF;
          state_d = S_FIN;
        end else begin
          cand_d = cand_sum[RW-1:0];
          cm_d   = (cm_sum >= {1'b0, d_q}) ? DW'(cm_sum - {1'b0, d_q}) : cm_sum[DW-1:0];
        end
      end
      S_QUOT: begin
        if (div_done) begin
          mul_start = 1'b1;
          state_d   = S_MUL;
        end
      end
      S_MUL: begin
        state_d = S_WAITMUL;
      end
      S_WAITMUL: begin
        if (mul_done) begin
          if (mul_prod[RW+DW-1:RW] != '0) begin
            fault_d = ST_OVF;
          end else begin
            mod_d = mul_prod[RW-1:0];
          end
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!last_q) begin
          state_d = S_IDLE;
        end else if (!ovalid_q || m_axis_tready) begin
          ovalid_d = 1'b1;
          ostat_d  = fault_q;
          if (fault_q == ST_OK) begin
            odata_d = {32'(mod_q), 32'(sol_q)};
          end else begin
            odata_d = '0;
          end
          sol_d   = '0;
          mod_d   = RW'(1);
          fault_d = ST_OK;
          first_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      fault_q  <= ST_OK;
      first_q  <= 1'b1;
      sol_q    <= '0;
      mod_q    <= RW'(1);
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      fault_q  <= fault_d;
      first_q  <= first_d;
      sol_q    <= sol_d;
      mod_q    <= mod_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q  <= last_d;
    cand_q  <= cand_d;
    d_q     <= d_d;
    r_q     <= r_d;
    y_q     <= y_d;
    g_q     <= g_d;
    t_q     <= t_d;
    cm_q    <= cm_d;
    sm_q    <= sm_d;
    odata_q <= odata_d;
    ostat_q <= ostat_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ostat_q;

  // The running candidate residue stays a proper remainder of the divisor.
  a_cm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SIEVE |-> cm_q < d_q) else $error("sieve residue out of range");
  // Sieving is only done once a system has its first pair.
  a_sieve_started: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SIEVE |-> !first_q && fault_q == ST_OK) else $error("bad sieve entry");
  // A new result only appears from the finishing step of a last pair.
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == S_FIN && last_q))
    else $error("result without last pair");
  // A faulted result carries zero payload.
  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata == '0)
    else $error("faulted result with data");
  // Every division of a pair has finished before the next pair is taken.
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !div_busy) else $error("divider busy between pairs");

endmodule

// ----- tb/crt_sieve_solver_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_sieve_solver_tb
// Self-checking bench for the congruence sieve solver. Pairs are fed through
// the slave stream with random gaps; a local solver model predicts each
// system's solution, modulus and status, and the monitor compares them with
// the master words in order. Directed systems cover the fault cases first.
// ----------------------------------------------------------------------------
module crt_sieve_solver_tb;
  import crt_pkg::*;

  localparam int unsigned RES_BITS = 32;
  localparam longint unsigned RES_MAX = 64'hFFFF_FFFF;

  typedef struct packed {
    logic [15:0] divisor;
    logic [15:0] residual;
    logic        last_pair;
  } pair_t;

  typedef struct packed {
    logic [31:0] solution;
    logic [31:0] modulus;
    status_e     status;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  crt_sieve_solver u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  pair_t   pending_pairs[$];
  answer_t expected_answers[$];
  int      mismatch_count = 0;
  int      words_sent = 0;
  bit      stimulus_done = 1'b0;
  bit      quiet_phase = 1'b0;
  int      hold_cycles = 0;

  // Model state of the running system.
  longint unsigned sol_q, mod_q;
  status_e fault_q;
  bit first_q;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint unsigned gcd64(longint unsigned a, longint unsigned b);
    longint unsigned t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  task automatic clear_system();
    sol_q = 0;
    mod_q = 1;
    fault_q = ST_OK;
    first_q = 1'b1;
  endtask

  task automatic merge_pair(pair_t p);
    longint unsigned d, r, g, cand, step;
    answer_t a;
    d = p.divisor;
    r = p.residual;
    if (fault_q == ST_OK) begin
      if (r >= d) begin
        fault_q = ST_RANGE;
      end else if (first_q) begin
        first_q = 1'b0;
        sol_q = r;
        mod_q = d;
      end else begin
        step = mod_q;
        g = gcd64(step, d);
        if (sol_q % g != r % g) begin
          fault_q = ST_NOSOL;
        end else begin
          cand = sol_q;
          while (cand % d != r && fault_q == ST_OK) begin
            if (cand > RES_MAX - step) fault_q = ST_OVF;
            else cand += step;
          end
          if (fault_q == ST_OK) begin
            sol_q = cand;
            if (step / g > RES_MAX / d) fault_q = ST_OVF;
            else mod_q = (step / g) * d;
          end
        end
      end
    end
    if (p.last_pair) begin
      a.status = fault_q;
      a.solution = (fault_q == ST_OK) ? sol_q[31:0] : '0;
      a.modulus = (fault_q == ST_OK) ? mod_q[31:0] : '0;
      expected_answers.push_back(a);
      clear_system();
    end
  endtask

  function automatic pair_t make_pair(int d, int r, bit l);
    pair_t p;
    p.divisor = d[15:0];
    p.residual = r[15:0];
    p.last_pair = l;
    return p;
  endfunction

  // Driver: offers the queue head, idles at random outside the quiet phase.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        merge_pair(pending_pairs.pop_front());
        words_sent <= words_sent + 1;
      end
      if (pending_pairs.size() != 0 && (quiet_phase || $urandom_range(99) >= 34)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {pending_pairs[0].residual, pending_pairs[0].divisor};
        s_axis_tlast <= pending_pairs[0].last_pair;
      end else if (!(s_axis_tvalid && !s_axis_tready)) begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: compares each taken word with the oldest prediction.
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_answers.size() == 0) begin
          $display("%0t: unexpected word sol=%h mod=%h st=%0d", $time,
                   m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = expected_answers.pop_front();
          if (want.solution !== m_axis_tdata[31:0] || want.modulus !== m_axis_tdata[63:32]
              || want.status !== m_axis_tuser) begin
            $display("%0t: expected sol=%h mod=%h st=%0d, got sol=%h mod=%h st=%0d",
                     $time, want.solution, want.modulus, want.status,
                     m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= quiet_phase || $urandom_range(99) >= 34;
      end
    end
  end

  // Random systems: mostly small coprime-ish divisors that stay solvable,
  // with the odd range fault, wide divisor or noisy residual.
  task automatic queue_random_system();
    int n, d, r, kind;
    n = $urandom_range(4, 1);
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(99);
      if (kind < 70) d = $urandom_range(40, 1);
      else if (kind < 90) d = $urandom_range(1000, 2);
      else d = $urandom_range(65535, 1);
      if (kind % 17 == 0) r = $urandom_range(65535);
      else r = $urandom_range(d - 1);
      pending_pairs.push_back(make_pair(d, r, i == n - 1));
    end
  endtask

  initial begin
    int queued;
    clear_system();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Directed: bit extremes, every fault kind, fault followed by ignored pairs.
    pending_pairs.push_back(make_pair(65535, 65534, 1));
    pending_pairs.push_back(make_pair(1, 0, 1));
    pending_pairs.push_back(make_pair(3, 2, 0));
    pending_pairs.push_back(make_pair(5, 3, 0));
    pending_pairs.push_back(make_pair(7, 2, 1));
    pending_pairs.push_back(make_pair(4, 4, 1));
    pending_pairs.push_back(make_pair(0, 0, 1));
    pending_pairs.push_back(make_pair(6, 1, 0));
    pending_pairs.push_back(make_pair(4, 2, 1));
    pending_pairs.push_back(make_pair(5, 9, 0));
    pending_pairs.push_back(make_pair(3, 1, 1));
    pending_pairs.push_back(make_pair(65521, 100, 0));
    pending_pairs.push_back(make_pair(65519, 5, 0));
    pending_pairs.push_back(make_pair(65497, 7, 1));
    pending_pairs.push_back(make_pair(43690, 21845, 0));
    pending_pairs.push_back(make_pair(21845, 0, 1));
    pending_pairs.push_back(make_pair(32768, 32767, 0));
    pending_pairs.push_back(make_pair(2, 1, 1));
    queued = 18;
    // Long receiver stall while the sender keeps offering.
    quiet_phase = 1'b1;
    hold_cycles = 3000;
    while (queued < 750) begin
      queue_random_system();
      queued = pending_pairs.size() + words_sent;
    end
    repeat (4000) @(posedge clk_i);
    quiet_phase = 1'b0;
    wait (pending_pairs.size() == 0 && !s_axis_tvalid);
    wait (expected_answers.size() == 0);
    repeat (2000) @(posedge clk_i);
    if (mismatch_count == 0 && expected_answers.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // The limit covers the longest possible sieve of every word, with room for
  // the random gaps and stalls.
  initial begin
    #3s;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
